/* sv/radio_rx_sync_phr_deframer_core_defines.svh */
// Assertion macros for the receive deframer RTL.
`ifndef RADIO_RX_SYNC_PHR_DEFRAMER_CORE_DEFINES_SVH
`define RADIO_RX_SYNC_PHR_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RXDFR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RXDFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rxdfr_pkg.sv */
// Types, codes and constants of the receive sync/PHR deframer.
package rxdfr_pkg;

    localparam int FIFO_DEPTH = 128;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [31:0]        SYNC_PAT_RST   = 32'h930B_51DE;
    localparam logic signed [7:0]  RSSI_RST       = -8'sd60;
    localparam logic               GDO0_MODE_RST  = 1'b1;
    localparam logic               GDO2_MODE_RST  = 1'b0;
    localparam logic [7:0]         STATUS_CRC_OK  = 8'h80;
    localparam logic [10:0]        LEN_MAX        = 11'(FIFO_DEPTH - 2);

    // Input word kinds
    localparam logic [2:0] KIND_AIR   = 3'd0;
    localparam logic [2:0] KIND_READ  = 3'd1;
    localparam logic [2:0] KIND_RX    = 3'd2;
    localparam logic [2:0] KIND_FLUSH = 3'd3;
    localparam logic [2:0] KIND_IDLE  = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_SYNC_PAT  = 2'd0;
    localparam logic [1:0] CFG_RSSI      = 2'd1;
    localparam logic [1:0] CFG_GDO0_MODE = 2'd2;
    localparam logic [1:0] CFG_GDO2_MODE = 2'd3;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RX   = 2'd1,
        MODE_ERR  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HDR  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] air_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [1:0]  mode;
        logic [7:0]  fifo_count;
        logic        gdo0_pin;
        logic        gdo2_pin;
        logic        packet_done;
        logic [31:0] packet_total;
    } out_word_t;

    // Strobes from the parser decode to the FIFO datapath
    typedef struct packed {
        logic       push;
        logic       pop;
        logic       status;
        logic [7:0] push_data;
    } fifo_act_t;

endpackage

/* sv/radio_rx_sync_phr_deframer_core.sv */
// Receive deframer: sync word hunt, two-byte PHR, payload into a 128-entry RX FIFO.
//
// Takes one word per clock: each accepted input word is decoded in a single pass
// and its status word lands in the output register on the next edge, so the
// block sustains one word per cycle unless the output stalls. in_ready only
// drops while a finished status word waits on a stalled output. Air bytes are
// used only in RX mode. In hunt, each byte shifts into a 32-bit register that
// is compared against the configured sync pattern; a match moves to the PHR and
// raises whichever GDO lines are set to sync mode. Both PHR bytes are pushed and
// give an 11-bit length; zero or more than depth minus 2 is an error. Payload
// bytes are pushed until the length runs out; if another entry is held, the last
// byte is stored as 0x80 (CRC ok) and the entry before it is rewritten with the RSSI
// in the cycle after, through the same single FIFO write port, which is always free
// then because the parser has just gone back to hunt. A read of that entry in the
// meantime is bypassed from the pending write. FIFO contents have no reset; only
// pushed entries are ever read. Configuration writes (cfg_we, cfg_index, cfg_data)
// take effect at once and must only be issued while the block is idle.
module radio_rx_sync_phr_deframer_core
    import rxdfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  in_word_t    in_data,

    output logic        out_valid,
    input  logic        out_ready,
    output out_word_t   out_data,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // Configuration
    logic [31:0]       sync_pat_reg;
    logic signed [7:0] rssi_reg;
    logic              gdo0_mode_reg;
    logic              gdo2_mode_reg;

    // Parser and FIFO control state
    mode_t               mode_reg, mode_next;
    phase_t              phase_reg, phase_next;
    logic [31:0]         sync_shift_reg, sync_shift_next;
    logic                hdr_idx_reg, hdr_idx_next;
    logic [10:0]         len_total_reg, len_total_next;
    logic [10:0]         len_left_reg, len_left_next;
    logic [FIFO_AW-1:0]  head_reg, head_next;
    logic [FIFO_AW-1:0]  tail_reg, tail_next;
    logic [FIFO_CW-1:0]  fill_reg, fill_next;
    logic                gdo0_reg, gdo0_next;
    logic                gdo2_reg, gdo2_next;
    logic [31:0]         packets_reg, packets_next;
    logic                done;
    fifo_act_t           act;

    // Deferred RSSI write
    logic                pend_valid_reg;
    logic [FIFO_AW-1:0]  pend_addr_reg;
    logic [7:0]          pend_data_reg;

    // FIFO storage and read path
    logic [7:0]          fifo_mem [FIFO_DEPTH];
    logic [7:0]          rd_mem_reg;
    logic                rd_from_mem_reg, rd_from_mem_next;

    // Output register
    logic                out_valid_reg;
    out_word_t           res_reg, res_next;

    logic                in_fire;
    logic                push_fire;
    logic                fifo_full;
    logic                rd_bypass;
    logic [10:0]         hdr_len;
    logic [10:0]         left_dec;
    logic [31:0]         sync_cand;
    logic [FIFO_AW-1:0]  tail_inc;
    logic [FIFO_AW-1:0]  tail_dec;
    logic [FIFO_AW-1:0]  head_inc;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign push_fire = in_fire && act.push;

    assign fifo_full = (fill_reg == FIFO_CW'(FIFO_DEPTH));
    assign tail_inc  = (tail_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign tail_dec  = (tail_reg == '0) ? FIFO_AW'(FIFO_DEPTH - 1) : tail_reg - 1'b1;
    assign head_inc  = (head_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign sync_cand = {sync_shift_reg[23:0], in_data.air_byte};
    assign hdr_len   = {len_total_reg[10:8], in_data.air_byte};
    assign left_dec  = len_left_reg - 11'd1;

    // Next state of the parser, mode, FIFO pointers and GDO lines
    always_comb
    begin
        mode_next       = mode_reg;
        phase_next      = phase_reg;
        sync_shift_next = sync_shift_reg;
        hdr_idx_next    = hdr_idx_reg;
        len_total_next  = len_total_reg;
        len_left_next   = len_left_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        gdo0_next       = gdo0_reg;
        gdo2_next       = gdo2_reg;
        packets_next    = packets_reg;
        done            = 1'b0;
        act.push        = 1'b0;
        act.pop         = 1'b0;
        act.status      = 1'b0;
        act.push_data   = in_data.air_byte;

        case (in_data.kind)
            KIND_AIR:
            begin
                if (mode_reg == MODE_RX)
                begin
                    case (phase_reg)
                        PH_HUNT:
                        begin
                            sync_shift_next = sync_cand;
                            if (sync_cand == sync_pat_reg)
                            begin
                                phase_next   = PH_HDR;
                                hdr_idx_next = 1'b0;
                                gdo0_next    = gdo0_reg | gdo0_mode_reg;
                                gdo2_next    = gdo2_reg | gdo2_mode_reg;
                            end
                        end
                        PH_HDR:
                        begin
                            if (fifo_full)
                            begin
                                mode_next = MODE_ERR;
                                phase_next = PH_HUNT;
                                sync_shift_next = '0;
                                hdr_idx_next = 1'b0;
                                len_total_next = '0;
                                len_left_next = '0;
                                gdo0_next = 1'b0;
                            end
                            else
                            begin
                                act.push = 1'b1;
                                if (!hdr_idx_reg)
                                begin
                                    len_total_next = {in_data.air_byte[2:0], 8'h00};
                                    hdr_idx_next   = 1'b1;
                                end
                                else if (hdr_len == '0 || hdr_len > LEN_MAX)
                                begin
                                    // Bad length: both header bytes stay in the FIFO
                                    mode_next = MODE_ERR;
                                    phase_next = PH_HUNT;
                                    sync_shift_next = '0;
                                    hdr_idx_next = 1'b0;
                                    len_total_next = '0;
                                    len_left_next = '0;
                                    gdo0_next = 1'b0;
                                end
                                else
                                begin
                                    len_total_next = hdr_len;
                                    len_left_next  = hdr_len;
                                    phase_next     = PH_BODY;
                                    hdr_idx_next   = 1'b0;
                                end
                            end
                        end
                        PH_BODY:
                        begin
                            if (fifo_full)
                            begin
                                mode_next = MODE_ERR;
                                phase_next = PH_HUNT;
                                sync_shift_next = '0;
                                hdr_idx_next = 1'b0;
                                len_total_next = '0;
                                len_left_next = '0;
                                gdo0_next = 1'b0;
                            end
                            else
                            begin
                                act.push      = 1'b1;
                                len_left_next = left_dec;
                                if (left_dec == '0)
                                begin
                                    done = 1'b1;
                                    // One or more held: last byte becomes status
                                    if (fill_reg != '0)
                                    begin
                                        act.status    = 1'b1;
                                        act.push_data = STATUS_CRC_OK;
                                    end
                                    packets_next    = packets_reg + 32'd1;
                                    phase_next      = PH_HUNT;
                                    sync_shift_next = '0;
                                    hdr_idx_next    = 1'b0;
                                    len_total_next  = '0;
                                    len_left_next   = '0;
                                    gdo0_next       = 1'b0;
                                    gdo2_next       = 1'b0;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = PH_HUNT;
                        end
                    endcase
                end
            end
            KIND_READ:
            begin
                if (fill_reg != '0)
                begin
                    act.pop   = 1'b1;
                    head_next = head_inc;
                    fill_next = fill_reg - 1'b1;
                end
            end
            KIND_RX:
            begin
                mode_next       = MODE_RX;
                phase_next      = PH_HUNT;
                sync_shift_next = '0;
                hdr_idx_next    = 1'b0;
                len_total_next  = '0;
                len_left_next   = '0;
            end
            KIND_FLUSH:
            begin
                if (mode_reg != MODE_RX)
                begin
                    head_next = '0;
                    tail_next = '0;
                    fill_next = '0;
                    mode_next = MODE_IDLE;
                end
            end
            KIND_IDLE:
            begin
                mode_next       = MODE_IDLE;
                phase_next      = PH_HUNT;
                sync_shift_next = '0;
                hdr_idx_next    = 1'b0;
                len_total_next  = '0;
                len_left_next   = '0;
                gdo0_next       = 1'b0;
                gdo2_next       = 1'b0;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase

        if (act.push)
        begin
            tail_next = tail_inc;
            fill_next = fill_reg + 1'b1;
        end
    end

    // Status word for the output register
    assign rd_bypass = pend_valid_reg && (pend_addr_reg == head_reg);

    always_comb
    begin
        rd_from_mem_next     = act.pop && !rd_bypass;
        res_next.read_data   = (act.pop && rd_bypass) ? pend_data_reg : 8'h00;
        res_next.mode        = mode_next;
        res_next.fifo_count  = 8'(fill_next);
        res_next.gdo0_pin    = gdo0_next;
        res_next.gdo2_pin    = gdo2_next;
        res_next.packet_done = done;
        res_next.packet_total = packets_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_pat_reg  <= SYNC_PAT_RST;
            rssi_reg      <= RSSI_RST;
            gdo0_mode_reg <= GDO0_MODE_RST;
            gdo2_mode_reg <= GDO2_MODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SYNC_PAT:  sync_pat_reg  <= cfg_data;
                CFG_RSSI:      rssi_reg      <= $signed(cfg_data[7:0]);
                CFG_GDO0_MODE: gdo0_mode_reg <= cfg_data[0];
                CFG_GDO2_MODE: gdo2_mode_reg <= cfg_data[0];
                default:       sync_pat_reg  <= sync_pat_reg;
            endcase
        end
    end

    // Control state: advance only on an accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            phase_reg      <= PH_HUNT;
            sync_shift_reg <= '0;
            hdr_idx_reg    <= 1'b0;
            len_total_reg  <= '0;
            len_left_reg   <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            fill_reg       <= '0;
            gdo0_reg       <= 1'b0;
            gdo2_reg       <= 1'b0;
            packets_reg    <= '0;
        end
        else if (in_fire)
        begin
            mode_reg       <= mode_next;
            phase_reg      <= phase_next;
            sync_shift_reg <= sync_shift_next;
            hdr_idx_reg    <= hdr_idx_next;
            len_total_reg  <= len_total_next;
            len_left_reg   <= len_left_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            fill_reg       <= fill_next;
            gdo0_reg       <= gdo0_next;
            gdo2_reg       <= gdo2_next;
            packets_reg    <= packets_next;
        end
    end

    // Deferred RSSI write: valid in the cycle after a packet end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= in_fire && act.status;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && act.status)
        begin
            pend_addr_reg <= tail_dec;
            pend_data_reg <= $unsigned(rssi_reg);
        end
    end

    // FIFO memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            fifo_mem[tail_reg] <= act.push_data;
        end
        else if (pend_valid_reg)
        begin
            fifo_mem[pend_addr_reg] <= pend_data_reg;
        end
        if (in_fire)
        begin
            rd_mem_reg <= fifo_mem[head_reg];
        end
    end

    // Output register: hold the status word until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            rd_from_mem_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg   <= 1'b1;
            rd_from_mem_reg <= rd_from_mem_next;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        out_data           = res_reg;
        out_data.read_data = rd_from_mem_reg ? rd_mem_reg : res_reg.read_data;
    end

`include "radio_rx_sync_phr_deframer_core_defines.svh"

    // The RSSI write must never compete with a push for the write port
    `RXDFR_ASSERT_IMPL(a_wport_free, push_fire, !pend_valid_reg, "push during RSSI write")
    // Fill level stays within the FIFO depth
    `RXDFR_ASSERT_IMPL(a_fill_range, 1'b1, fill_reg <= FIFO_CW'(FIFO_DEPTH), "FIFO overfill")
    // Pointers only meet when the FIFO is empty or full
    `RXDFR_ASSERT_IMPL(a_ptr_fill, (fill_reg != '0) && !fifo_full, head_reg != tail_reg,
        "FIFO pointers disagree with fill")
    // A completed packet bumps the counter by exactly one
    `RXDFR_ASSERT_NEXT(a_pkt_count, in_fire && done, packets_reg == $past(packets_reg) + 32'd1,
        "packet counter did not advance")

endmodule
